// ----- rtl/lfsrs_pkg.sv -----
// lfsrs_pkg: shared constants, types and helpers for the LFSR frame scrambler.
// No dependencies; imported by every module of the block.
`default_nettype none

package lfsrs_pkg;

  // LFSR length (2..32)
  localparam int REG_BITS = 7;
  // width of the seed and tap_mask registers
  localparam int CFG_W = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SEED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TAPS = 1'b1;

  localparam logic [CFG_W-1:0] SEED_RST = 7'd127;
  localparam logic [CFG_W-1:0] TAPS_RST = 7'd72;

  typedef logic [REG_BITS-1:0] lfsr_t;
  typedef logic [REG_BITS-1:0] seq_pos_t;

  typedef struct packed {
    logic [CFG_W-1:0] seed;
    logic [CFG_W-1:0] tap_mask;
  } cfg_t;

  // Fit a register value to the LFSR length: zero-extend or drop high bits.
  function automatic lfsr_t fit_reg(input logic [CFG_W-1:0] v);
    logic [REG_BITS+CFG_W-1:0] ext;
    ext = {{REG_BITS{1'b0}}, v};
    return ext[REG_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/lfsrs_cfg_regs.sv -----
// lfsrs_cfg_regs: seed and tap_mask registers behind the plain write port.
// Depends on lfsrs_pkg.
`default_nettype none

module lfsrs_cfg_regs
  import lfsrs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                      cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_SEED: cfg_nxt.seed     = cfg_wdata;
        CFG_IDX_TAPS: cfg_nxt.tap_mask = cfg_wdata;
        default:      cfg_nxt          = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.seed     <= SEED_RST;
      cfg_r.tap_mask <= TAPS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- rtl/lfsrs_core.sv -----
// lfsrs_core: Fibonacci LFSR, sequence position counter and feedback parity.
// Depends on lfsrs_pkg.
`default_nettype none

module lfsrs_core
  import lfsrs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire logic step,
  input  wire logic frame_start,
  output logic      fb
);

  localparam seq_pos_t SEQ_LAST = '1;
  localparam seq_pos_t POS_ONE  = seq_pos_t'(1);

  lfsr_t    sr_r, sr_nxt;
  seq_pos_t pos_r, pos_nxt;
  lfsr_t    cur;
  logic     reload;

  // reload happens before this bit's feedback
  assign reload = frame_start || (pos_r == SEQ_LAST);
  assign cur    = reload ? fit_reg(cfg.seed) : sr_r;
  assign fb     = ^(cur & fit_reg(cfg.tap_mask));

  always_comb begin
    sr_nxt  = sr_r;
    pos_nxt = pos_r;
    if (step) begin
      sr_nxt  = {cur[REG_BITS-2:0], fb};
      pos_nxt = reload ? POS_ONE : pos_r + POS_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_r  <= fit_reg(SEED_RST);
      pos_r <= '0;
    end else begin
      sr_r  <= sr_nxt;
      pos_r <= pos_nxt;
    end
  end

  a_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
    step && frame_start |=> pos_r == POS_ONE)
    else $error("position not restarted at frame start");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(sr_r) && $stable(pos_r))
    else $error("LFSR state moved without a step");

  a_fb_in: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> sr_r[0] == $past(fb))
    else $error("feedback bit not shifted in");

endmodule

`default_nettype wire

// ----- rtl/lfsr_frame_scrambler.sv -----
// lfsr_frame_scrambler: top level, input register, output register, handshakes.
// Depends on lfsrs_pkg, lfsrs_cfg_regs and lfsrs_core.
`default_nettype none

// Additive bit scrambler (x^7 + x^4 + 1 by default reset values).
//
// Input channel: in_valid/in_ready carry one data bit plus a frame_start
// flag per transfer. A set frame_start reloads the LFSR from seed before
// that bit is scrambled; the LFSR also reloads after every 2^REG_BITS-1 bits.
// Output channel: out_valid/out_ready carry one scrambled_bit per input bit,
// in order.
//
// Path: an input transfer lands in the input register, then the feedback
// parity goes into the output register, which drives out_valid. Throughput:
// one bit per clock while out_ready stays high; the LFSR step is a single XOR
// tree over REG_BITS bits.
//
// Stall: when out_ready is low the output register holds; one more bit may
// sit in the input register, after which in_ready drops. No bit is lost.
//
// Reset (rst_n low, synchronous): both stages empty, seed = 127,
// tap_mask = 72, LFSR = seed, position = 0. Configuration writes on cfg_we
// take effect at once; write only while the pipeline is empty. A new seed
// is used at the next reload.
module lfsr_frame_scrambler
  import lfsrs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_data_bit,
  input  wire logic                 in_frame_start,
  // output channel
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_scrambled_bit
);

  cfg_t cfg;

  // input stage
  logic s1_valid_r, s1_valid_nxt;
  logic s1_data_r;
  logic s1_start_r;
  // output stage
  logic out_valid_r, out_valid_nxt;
  logic out_bit_r;

  logic advance;   // input stage moves into the output register
  logic in_xfer;
  logic fb;

  lfsrs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lfsrs_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .step        (advance),
    .frame_start (s1_start_r),
    .fb          (fb)
  );

  // output register frees up in the same cycle it is taken
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r  <= in_data_bit;
      s1_start_r <= in_frame_start;
    end
    if (advance) begin
      out_bit_r <= s1_data_r ^ fb;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_scrambled_bit = out_bit_r;

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// tb: self-checking bench for lfsr_frame_scrambler, with a bit-exact LFSR predictor.
// Depends on lfsrs_pkg and the lfsr_frame_scrambler RTL; reads no files.
module tb;
  import lfsrs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // scrambling sequence repeats every 2^N - 1 bits
  localparam int SEQ_LEN = (1 << REG_BITS) - 1;
  // output lags input by two stages; a few spare cycles before config writes
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_LIMIT = 5000;
  localparam int HOLD_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_IDX_SEED;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_data_bit = 1'b0;
  logic in_frame_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_scrambled_bit;

  lfsr_frame_scrambler dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data_bit(in_data_bit),
    .in_frame_start(in_frame_start),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_scrambled_bit(out_scrambled_bit)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the config and the LFSR.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] seed_q;
  logic [CFG_W-1:0] taps_q;
  lfsr_t lfsr_q;
  int seq_pos;

  logic pending_bits[$];    // scrambled bits still owed by the block
  int errors = 0;
  int results_seen = 0;

  // Idle / stall knobs, percent of cycles
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  // Long receiver hold-off request; the receiver process counts it out
  logic hold_req = 1'b0;
  int hold_left = 0;

  // Frame generator state, carried across phases so a phase may start mid-frame
  int frame_left = 0;

  function automatic void reset_predictor();
    seed_q = SEED_RST;
    taps_q = TAPS_RST;
    lfsr_q = lfsr_t'(SEED_RST);
    seq_pos = 0;
  endfunction

  // One LFSR step: reload on frame start or sequence wrap, XOR the tapped
  // bits into the feedback, shift it in at bit 0, and scramble the data bit.
  function automatic logic scramble_bit(input logic data, input logic start);
    logic fb;
    if (start || seq_pos >= SEQ_LEN) begin
      lfsr_q = lfsr_t'(seed_q);
      seq_pos = 0;
    end
    fb = ^(lfsr_q & lfsr_t'(taps_q));
    lfsr_q = {lfsr_q[REG_BITS-2:0], fb};
    seq_pos++;
    return data ^ fb;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Driving tasks
  // ---------------------------------------------------------------------------
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_IDX_SEED) seed_q = val;
    else if (idx == CFG_IDX_TAPS) taps_q = val;
  endtask

  // Offer one bit; on transfer, step the predictor and queue the expected bit.
  // A typed-in expectation (known) overrides the predictor output.
  task automatic send_bit(input logic data, input logic start, input logic known,
                          input logic want);
    logic pred;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_bit <= data;
    in_frame_start <= start;
    do @(posedge clk); while (!in_ready);
    pred = scramble_bit(data, start);
    pending_bits.push_back(known ? want : pred);
  endtask

  // Drop valid and wait for every owed bit, then let the pipeline settle.
  task automatic drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending_bits.size() != 0 && waited < DRAIN_LIMIT);
    if (pending_bits.size() != 0) begin
      report_mismatch($sformatf("%0d bits never came out", pending_bits.size()));
      pending_bits.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly short frames, one in ten long enough to cross the sequence wrap,
  // and now and then a stray frame start in the middle of a frame.
  task automatic send_random_bit();
    logic start;
    if (frame_left == 0) begin
      start = 1'b1;
      frame_left = ($urandom_range(9) == 0) ? $urandom_range(300, 128) : $urandom_range(40, 1);
    end else begin
      start = ($urandom_range(49) == 0);
    end
    frame_left--;
    send_bit(1'($urandom_range(1)), start, 1'b0, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Result checker: every output transfer against the oldest expectation.
  always @(posedge clk) begin
    logic want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_bits.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing expected", results_seen));
      end else begin
        want = pending_bits.pop_front();
        if (out_scrambled_bit !== want)
          report_mismatch($sformatf("result %0d scrambled_bit %b, expected %b",
                                    results_seen, out_scrambled_bit, want));
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed vectors, default config (seed 127, taps on bits 6 and 3).
  // From all ones the first four feedback bits are 0, the next ones 1.
  // known = 0 rows go through the predictor.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic data;
    logic start;
    logic known;
    logic want;
  } vec_t;

  vec_t dir_vecs [16] = '{
    // straight out of reset, no frame start: LFSR already holds the seed
    '{1'b1, 1'b0, 1'b1, 1'b1},
    '{1'b0, 1'b0, 1'b1, 1'b0},
    '{1'b1, 1'b0, 1'b1, 1'b1},
    '{1'b0, 1'b0, 1'b1, 1'b0},
    '{1'b0, 1'b0, 1'b1, 1'b1},
    '{1'b1, 1'b0, 1'b1, 1'b0},
    // frame start mid-sequence reloads the seed
    '{1'b1, 1'b1, 1'b1, 1'b1},
    // back-to-back frame starts
    '{1'b0, 1'b1, 1'b1, 1'b0},
    '{1'b1, 1'b1, 1'b1, 1'b1},
    '{1'b1, 1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 1'b0, 1'b0, 1'b0},
    '{1'b1, 1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b0, 1'b0}
  };

  // Random phases: config, idle mode, item count.
  typedef struct {
    logic [CFG_W-1:0] seed;
    logic [CFG_W-1:0] taps;
    int tx_pct;
    int rx_pct;
    int items;
  } phase_t;

  initial begin
    phase_t phases[8];
    reset_predictor();

    phases[0] = '{SEED_RST, TAPS_RST, 0, 0, 130};
    phases[1] = '{7'd0, TAPS_RST, 54, 0, 120};   // all-zero seed: data passes once reloaded
    phases[2] = '{7'd127, 7'd0, 0, 54, 120};     // no taps: data passes
    phases[3] = '{7'd127, 7'd127, 36, 36, 130};
    phases[4] = '{CFG_W'($urandom_range(127)), CFG_W'($urandom_range(127)), 0, 0, 130};
    phases[5] = '{7'd1, 7'd96, 54, 0, 130};
    phases[6] = '{CFG_W'($urandom_range(127)), CFG_W'($urandom_range(127)), 0, 54, 130};
    phases[7] = '{CFG_W'($urandom_range(127)), CFG_W'($urandom_range(127)), 36, 36, 130};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_vecs[i])
      send_bit(dir_vecs[i].data, dir_vecs[i].start, dir_vecs[i].known, dir_vecs[i].want);
    drain();

    foreach (phases[p]) begin
      // block is idle here; the LFSR state carries across the write
      write_cfg(CFG_IDX_SEED, phases[p].seed);
      write_cfg(CFG_IDX_TAPS, phases[p].taps);
      tx_idle_pct = phases[p].tx_pct;
      rx_stall_pct = phases[p].rx_pct;
      for (int n = 0; n < phases[p].items; n++) begin
        // long receiver hold-off while the sender keeps pushing
        if (p == 4 && n == 40) hold_req = 1'b1;
        // sender pause until the block has handed back everything
        if (p == 5 && n == 60) drain();
        send_random_bit();
      end
      drain();
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/lfsrs_pkg.sv
rtl/lfsrs_cfg_regs.sv
rtl/lfsrs_core.sv
rtl/lfsr_frame_scrambler.sv
tb/sv/tb.sv
